// File: rtl/qsar_pkg.sv
// Shared widths, constants and control types for the QRS speed/amplitude ratio block.
`default_nettype none

package qsar_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int FRACTION_BITS = 8;

   localparam int RATIO_BITS  = 16;
   localparam int RATIO_SCALE = 100;
   localparam int SCALE_BITS  = 7;
   localparam int DIFF_BITS   = SAMPLE_BITS + 2;
   localparam int PEAK_BITS   = SAMPLE_BITS + 2;
   localparam int AMP_BITS    = SAMPLE_BITS;
   localparam int NUM_BITS    = PEAK_BITS + SCALE_BITS + FRACTION_BITS;
   localparam int CNT_BITS    = $clog2(NUM_BITS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic take;    // sample item accepted this cycle
      logic load;    // start divide, clear segment state
      logic step;    // one quotient bit
      logic finish;  // write result register
   } cmd_type;

   typedef struct packed {
      logic div_done;  // current step is the final one
   } status_type;

endpackage

`default_nettype wire

// File: rtl/qrs_speed_amplitude_ratio.sv
// Top level of the QRS speed-to-amplitude ratio block.
//
// Usage:
//   req_*  : one ECG sample per item (req_sample, signed), req_last marks the
//            final sample of a QRS segment.
//   rsp_*  : one item per segment: rsp_ratio = 100 * peak |second difference|
//            / (max - min), unsigned with FRACTION_BITS fraction bits, floor,
//            saturated to the field; rsp_zero_amplitude set (ratio 0) when
//            max equals min. Max and min both start at zero each segment.
// Throughput and sequence:
//   Samples without req_last are taken one per cycle while req_stall is low.
//   A sample with req_last moves the block through the load, divide and
//   finish states; the restoring divider, one quotient bit per cycle, works
//   out all NUM_BITS (33 at default widths) quotient bits. The result shows
//   on rsp_valid in the same cycle that req_stall drops.
// Stalls:
//   The result sits in an output register; the block keeps taking samples of
//   the next segment while it waits. A second finished result waits in the
//   finish state (req_stall high) until the first is taken.
// Reset: synchronous, clears all segment state and drops rsp_valid.
`default_nettype none

module qrs_speed_amplitude_ratio (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [qsar_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                   req_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [qsar_pkg::RATIO_BITS-1:0]             rsp_ratio,
   output logic                                        rsp_zero_amplitude
);

   qsar_pkg::cmd_type    cmd;
   qsar_pkg::status_type status;

   // controller: handshakes, sequencing of load / divide / finish
   qsar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: trackers, scaling multiply, divider and result register
   qsar_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_sample         (req_sample),
      .cmd                (cmd),
      .status             (status),
      .rsp_ratio          (rsp_ratio),
      .rsp_zero_amplitude (rsp_zero_amplitude)
   );

endmodule

`default_nettype wire

// File: rtl/qsar_ctrl.sv
// Sequencer for the QRS speed/amplitude ratio block: handshakes and divide control.
`default_nettype none

module qsar_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output qsar_pkg::cmd_type        cmd,
   input  wire qsar_pkg::status_type status
);

   qsar_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != qsar_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         qsar_pkg::ST_IDLE: begin
            cmd.take = req_valid;
            if (req_valid && req_last) begin
               state_in = qsar_pkg::ST_LOAD;
            end
         end
         qsar_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = qsar_pkg::ST_DIVIDE;
         end
         qsar_pkg::ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = qsar_pkg::ST_FINISH;
            end
         end
         qsar_pkg::ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = qsar_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qsar_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qsar_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/qsar_dp.sv
// Datapath: segment trackers, numerator scaling, restoring divider, result register.
`default_nettype none

module qsar_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic signed [qsar_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire qsar_pkg::cmd_type                     cmd,
   output qsar_pkg::status_type                       status,
   output logic [qsar_pkg::RATIO_BITS-1:0]            rsp_ratio,
   output logic                                       rsp_zero_amplitude
);

   localparam int SB = qsar_pkg::SAMPLE_BITS;
   localparam int DB = qsar_pkg::DIFF_BITS;
   localparam int PB = qsar_pkg::PEAK_BITS;
   localparam int AB = qsar_pkg::AMP_BITS;
   localparam int NB = qsar_pkg::NUM_BITS;
   localparam int CB = qsar_pkg::CNT_BITS;
   localparam int RB = qsar_pkg::RATIO_BITS;
   localparam int XB = qsar_pkg::PEAK_BITS + qsar_pkg::SCALE_BITS;

   // segment trackers
   logic signed [SB-1:0] prev1_ff, prev1_in;
   logic signed [SB-1:0] prev2_ff, prev2_in;
   logic        [1:0]    seen_ff, seen_in;
   logic        [PB-1:0] peak_ff, peak_in;
   logic signed [SB-1:0] high_ff, high_in;
   logic signed [SB-1:0] low_ff, low_in;

   // divider
   logic [NB-1:0] quo_ff, quo_in;
   logic [AB-1:0] rem_ff, rem_in;
   logic [AB-1:0] div_ff, div_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          zero_ff, zero_in;

   // result
   logic [RB-1:0] ratio_ff, ratio_in;
   logic          flag_ff, flag_in;

   logic signed [DB-1:0] diff;
   logic        [PB-1:0] mag;
   logic signed [SB:0]   amp_wide;
   logic        [AB-1:0] amp;
   logic        [XB-1:0] scaled;
   logic        [AB:0]   trial;
   logic                 fits;
   logic        [RB-1:0] quo_sat;

   // second difference s + s[-2] - 2*s[-1]
   always_comb begin
      diff = DB'(req_sample) + DB'(prev2_ff) - (DB'(prev1_ff) <<< 1);
      mag  = diff[DB-1] ? PB'(-diff) : PB'(diff);
   end

   assign amp_wide = (SB+1)'(high_ff) - (SB+1)'(low_ff);
   assign amp      = amp_wide[AB-1:0];
   assign scaled   = XB'(peak_ff) * XB'(qsar_pkg::RATIO_SCALE);

   assign trial = {rem_ff, quo_ff[NB-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   assign quo_sat = (|quo_ff[NB-1:RB]) ? {RB{1'b1}} : quo_ff[RB-1:0];

   assign status.div_done = (cnt_ff == '0);

   always_comb begin
      prev1_in = prev1_ff;
      prev2_in = prev2_ff;
      seen_in  = seen_ff;
      peak_in  = peak_ff;
      high_in  = high_ff;
      low_in   = low_ff;
      if (cmd.load) begin
         prev1_in = '0;
         prev2_in = '0;
         seen_in  = '0;
         peak_in  = '0;
         high_in  = '0;
         low_in   = '0;
      end else if (cmd.take) begin
         if (seen_ff[1] && (mag > peak_ff)) begin
            peak_in = mag;
         end
         if (req_sample > high_ff) begin
            high_in = req_sample;
         end
         if (req_sample < low_ff) begin
            low_in = req_sample;
         end
         prev2_in = prev1_ff;
         prev1_in = req_sample;
         if (!seen_ff[1]) begin
            seen_in = seen_ff + 2'd1;
         end
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      if (cmd.load) begin
         quo_in  = NB'(scaled) << qsar_pkg::FRACTION_BITS;
         rem_in  = '0;
         div_in  = amp;
         cnt_in  = CB'(NB - 1);
         zero_in = (amp == '0);
      end else if (cmd.step) begin
         quo_in = {quo_ff[NB-2:0], fits};
         rem_in = fits ? AB'(trial - {1'b0, div_ff}) : trial[AB-1:0];
         cnt_in = cnt_ff - CB'(1);
      end
   end

   always_comb begin
      ratio_in = ratio_ff;
      flag_in  = flag_ff;
      if (cmd.finish) begin
         ratio_in = zero_ff ? '0 : quo_sat;
         flag_in  = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev1_ff <= '0;
         prev2_ff <= '0;
         seen_ff  <= '0;
         peak_ff  <= '0;
         high_ff  <= '0;
         low_ff   <= '0;
      end else begin
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
         seen_ff  <= seen_in;
         peak_ff  <= peak_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      zero_ff  <= zero_in;
      ratio_ff <= ratio_in;
      flag_ff  <= flag_in;
   end

   assign rsp_ratio          = ratio_ff;
   assign rsp_zero_amplitude = flag_ff;

endmodule

`default_nettype wire

// File: rtl/qsar_checker.sv
// Port-level assertions for the QRS speed/amplitude ratio block, with bind.
`default_nettype none

module qsar_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_stall,
   input wire logic signed [qsar_pkg::SAMPLE_BITS-1:0] req_sample,
   input wire logic                                   req_last,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic [qsar_pkg::RATIO_BITS-1:0]        rsp_ratio,
   input wire logic                                   rsp_zero_amplitude
);

   logic seg_end;
   assign seg_end = req_valid && !req_stall && req_last;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_zero_ratio: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_amplitude) |-> (rsp_ratio == '0))
      else $error("zero amplitude with nonzero ratio");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      seg_end |=> req_stall)
      else $error("input not stalled while dividing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_ratio) && $stable(rsp_zero_amplitude)))
      else $error("stalled result changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable(req_sample) && $stable(req_last)))
      else $error("stalled input item changed");

endmodule

bind qrs_speed_amplitude_ratio qsar_checker u_qsar_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_sample         (req_sample),
   .req_last           (req_last),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_ratio          (rsp_ratio),
   .rsp_zero_amplitude (rsp_zero_amplitude)
);

`default_nettype wire

// File: tb/sv/qrs_ratio_checker.sv
// Checker for the QRS speed/amplitude ratio block: predicts per-segment ratios and compares.
module qrs_ratio_checker (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   input  wire logic                                    req_stall,
   input  wire logic signed [qsar_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                    req_last,
   input  wire logic                                    rsp_valid,
   input  wire logic                                    rsp_stall,
   input  wire logic [qsar_pkg::RATIO_BITS-1:0]         rsp_ratio,
   input  wire logic                                    rsp_zero_amplitude,
   output int                                           fault_count,
   output int                                           results_due
);

   localparam longint RATIO_LIMIT = (longint'(1) << qsar_pkg::RATIO_BITS) - 1;
   localparam int     REPORT_LIMIT = 10;

   typedef struct packed {
      logic [qsar_pkg::RATIO_BITS-1:0] ratio;
      logic                            zero_amplitude;
   } ratio_result_type;

   ratio_result_type awaited_ratios[$];
   ratio_result_type oldest;

   // running segment state
   logic signed [qsar_pkg::SAMPLE_BITS-1:0] prior_one;
   logic signed [qsar_pkg::SAMPLE_BITS-1:0] prior_two;
   logic signed [qsar_pkg::SAMPLE_BITS-1:0] highest;
   logic signed [qsar_pkg::SAMPLE_BITS-1:0] lowest;
   logic [1:0]                              seen;
   logic [qsar_pkg::PEAK_BITS-1:0]          peak_speed;

   task automatic clear_segment();
      prior_one  = '0;
      prior_two  = '0;
      highest    = '0;
      lowest     = '0;
      seen       = '0;
      peak_speed = '0;
   endtask

   task automatic report_fault(input string what);
      if (fault_count < REPORT_LIMIT)
         $display("%0t: %s", $realtime, what);
      fault_count++;
   endtask

   // Fold one accepted sample into the segment; on the last one queue the ratio.
   task automatic fold_sample(input logic signed [qsar_pkg::SAMPLE_BITS-1:0] s,
                              input logic ends);
      int               curve;
      int               amplitude;
      longint           quotient;
      ratio_result_type entry;
      if (seen == 2'd2) begin
         curve = int'(s) + int'(prior_two) - 2 * int'(prior_one);
         if (curve < 0)
            curve = -curve;
         if (curve > int'(peak_speed))
            peak_speed = curve[qsar_pkg::PEAK_BITS-1:0];
      end
      if (s > highest)
         highest = s;
      if (s < lowest)
         lowest = s;
      prior_two = prior_one;
      prior_one = s;
      if (seen != 2'd2)
         seen = seen + 2'd1;
      if (ends) begin
         amplitude = int'(highest) - int'(lowest);
         if (amplitude == 0) begin
            entry.ratio          = '0;
            entry.zero_amplitude = 1'b1;
         end else begin
            quotient = ((longint'(peak_speed) * qsar_pkg::RATIO_SCALE)
                        << qsar_pkg::FRACTION_BITS) / amplitude;
            if (quotient > RATIO_LIMIT)
               quotient = RATIO_LIMIT;
            entry.ratio          = quotient[qsar_pkg::RATIO_BITS-1:0];
            entry.zero_amplitude = 1'b0;
         end
         awaited_ratios.insert(awaited_ratios.size(), entry);
         clear_segment();
      end
   endtask

   // Results are checked before samples so a result can never match an
   // expectation queued at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_segment();
         awaited_ratios.delete();
         fault_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_ratios.size() == 0) begin
               report_fault($sformatf("unexpected result: ratio %0d zero_amplitude %0b",
                                      rsp_ratio, rsp_zero_amplitude));
            end else begin
               oldest = awaited_ratios.pop_front();
               if (oldest.ratio !== rsp_ratio ||
                   oldest.zero_amplitude !== rsp_zero_amplitude)
                  report_fault($sformatf(
                     "mismatch: ratio exp %0d got %0d, zero_amplitude exp %0b got %0b",
                     oldest.ratio, rsp_ratio, oldest.zero_amplitude, rsp_zero_amplitude));
            end
         end
         if (req_valid && !req_stall)
            fold_sample(req_sample, req_last);
      end
      results_due = awaited_ratios.size();
   end

endmodule

// File: tb/sv/qrs_speed_amplitude_ratio_tb.sv
// Testbench top for the QRS speed/amplitude ratio block: stimulus, idling and verdict.
module qrs_speed_amplitude_ratio_tb;

   localparam int SB = qsar_pkg::SAMPLE_BITS;
   localparam int ITEM_TARGET = 1200;
   localparam int DRAIN_CYCLES = 60;

   // sample shapes for a segment
   typedef enum int {
      WAVE_FULL,
      WAVE_SMALL,
      WAVE_POSITIVE,
      WAVE_NEGATIVE,
      WAVE_FLAT,
      WAVE_SPIKE
   } wave_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic signed [SB-1:0]               req_sample;
   logic                               req_last;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [qsar_pkg::RATIO_BITS-1:0]    rsp_ratio;
   logic                               rsp_zero_amplitude;

   int fault_count;
   int results_due;
   int items_sent;
   bit steady;       // no sender gaps for the current segment
   int stall_hold;   // cycles left in the current stall/go run
   int stall_roll;

   qrs_speed_amplitude_ratio dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ratio          (rsp_ratio),
      .rsp_zero_amplitude (rsp_zero_amplitude)
   );

   qrs_ratio_checker ratio_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ratio          (rsp_ratio),
      .rsp_zero_amplitude (rsp_zero_amplitude),
      .fault_count        (fault_count),
      .results_due        (results_due)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Result-side back-pressure. Runs of stall and go with random lengths:
   // mostly short flicker, sometimes a long quiet stretch, rarely a long stall
   // so that finished results pile up behind the output register.
   always @(negedge clock) begin
      if (stall_hold != 0) begin
         stall_hold = stall_hold - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 45) begin
            rsp_stall <= 1'b0;
            stall_hold = $urandom_range(0, 4);
         end else if (stall_roll < 85) begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(0, 3);
         end else if (stall_roll < 95) begin
            rsp_stall <= 1'b0;
            stall_hold = $urandom_range(50, 300);
         end else begin
            rsp_stall <= 1'b1;
            stall_hold = $urandom_range(20, 80);
         end
      end
   end

   // Present one item at the current falling edge and hold it until taken.
   // Afterwards an optional idle gap: mostly none or short, a few long ones.
   // When there is no gap, valid simply stays high for the next item.
   task automatic send_item(input logic signed [SB-1:0] value, input logic ends);
      int gap;
      int roll;
      req_valid  <= 1'b1;
      req_sample <= value;
      req_last   <= ends;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      @(negedge clock);
      gap = 0;
      if (!steady) begin
         roll = $urandom_range(0, 99);
         if (roll >= 92)
            gap = $urandom_range(10, 40);
         else if (roll >= 50)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic signed [SB-1:0] draw_sample(
      input wave_type style, input logic signed [SB-1:0] level);
      logic signed [SB-1:0] value;
      int                   pick;
      case (style)
         WAVE_SMALL:    value = SB'($urandom_range(0, 40) - 20);
         WAVE_POSITIVE: value = SB'($urandom_range(1, 32767));
         WAVE_NEGATIVE: value = SB'(-$signed($urandom_range(1, 32768)));
         WAVE_FLAT:     value = level;
         WAVE_SPIKE: begin
            // half baseline, half rail-to-rail spikes: drives the peak
            // second difference toward twice the amplitude
            pick = $urandom_range(0, 3);
            if (pick == 0)
               value = 16'sh7fff;
            else if (pick == 1)
               value = 16'sh8000;
            else
               value = level;
         end
         default:       value = SB'($urandom());
      endcase
      return value;
   endfunction

   task automatic send_segment(input int length, input wave_type style);
      logic signed [SB-1:0] level;
      level = SB'($urandom());
      if ($urandom_range(0, 3) == 0)
         level = '0;   // flat at zero gives a zero amplitude
      for (int i = 0; i < length; i++)
         send_item(draw_sample(style, level), i == length - 1);
   endtask

   initial begin
      int       length;
      int       roll;
      wave_type style;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_sample = '0;
      req_last   = 1'b0;
      rsp_stall  = 1'b0;
      stall_hold = 0;
      items_sent = 0;
      steady     = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed segments ---
      // single zero sample: zero amplitude, flag set
      send_item(16'sd0, 1'b1);
      // single positive / negative extreme: short segment, ratio zero
      send_item(16'sh7fff, 1'b1);
      send_item(16'sh8000, 1'b1);
      // two samples: still no second difference
      send_item(16'sd100, 1'b0);
      send_item(-16'sd100, 1'b1);
      // rail-to-rail zigzag: largest ratio the block can produce
      send_item(16'sh7fff, 1'b0);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh7fff, 1'b1);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh7fff, 1'b0);
      send_item(16'sh8000, 1'b1);
      // constant nonzero: amplitude from the zero baseline, speed zero
      send_item(16'sd5, 1'b0);
      send_item(16'sd5, 1'b0);
      send_item(16'sd5, 1'b1);
      // constant zero over several samples: zero amplitude
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd0, 1'b1);
      // linear ramp: second difference is zero
      send_item(16'sd10, 1'b0);
      send_item(16'sd20, 1'b0);
      send_item(16'sd30, 1'b1);
      // small swing with full speed, then a quotient that truncates
      send_item(16'sd1, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(16'sd1, 1'b1);
      send_item(16'sd3, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd1, 1'b1);

      // --- random segments ---
      // Every sequence is well formed here; variety comes from segment
      // length and sample shape. Some segments run with no sender gaps.
      while (items_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 12)
            length = $urandom_range(1, 2);
         else if (roll < 80)
            length = $urandom_range(3, 12);
         else
            length = $urandom_range(13, 48);
         style  = wave_type'($urandom_range(0, 5));
         steady = ($urandom_range(0, 4) == 0);
         send_segment(length, style);
      end
      req_valid <= 1'b0;

      // drain: wait for every queued ratio, then let the divider settle
      while (results_due != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fault_count == 0 && results_due == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #6000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
